// ----- rtl/pcp_pkg.sv -----
package pcp_pkg;

   // Face table depth and the index/count widths that follow from it
   localparam int MAX_FACES  = 16;
   localparam int FACE_IDX_W = $clog2(MAX_FACES);
   localparam int FACE_CNT_W = FACE_IDX_W + 1;

   // Fixed field widths
   localparam int CMD_W      = 1;
   localparam int SLOT_W     = 4;
   localparam int NORM_W     = 16;
   localparam int COORD_W    = 32;
   localparam int DEPTH_W    = 31;
   localparam int CFG_CNT_W  = 5;
   localparam int TOL_W      = 16;

   // Datapath widths: 33-bit difference times 16-bit normal, sum of three
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = DIFF_W + NORM_W;
   localparam int DIST_W     = PROD_W + 1;
   localparam int FRAC_SHIFT = 14;
   localparam int ROUND_W    = DIST_W + 1;
   localparam int QUOT_W     = ROUND_W - FRAC_SHIFT;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_TOL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANT_MODE = 2'd2;

   localparam logic [CFG_CNT_W-1:0] FACE_COUNT_RST    = 5'd0;
   localparam logic [TOL_W-1:0]     SURFACE_TOL_RST   = 16'd7;
   localparam logic                 TOLERANT_MODE_RST = 1'b1;

   // Rounding offset for the Q.30 to Q16.16 step
   localparam logic [ROUND_W-1:0] ROUND_HALF = ROUND_W'(1) << (FRAC_SHIFT - 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX  = {DEPTH_W{1'b1}};

   // One face table entry
   typedef struct packed {
      logic signed [NORM_W-1:0]  nx;
      logic signed [NORM_W-1:0]  ny;
      logic signed [NORM_W-1:0]  nz;
      logic signed [COORD_W-1:0] rx;
      logic signed [COORD_W-1:0] ry;
      logic signed [COORD_W-1:0] rz;
   } face_entry_type;

endpackage

// ----- rtl/point_convex_penetration_top.sv -----
// Point-in-convex-body test. A load transfer (command 0) writes one face, a
// normal and a reference vertex, into the face table and gives no result. A
// query transfer (command 1) walks faces 0 to face_count-1, with face_count
// clamped to the table depth of 16, through a single shared 33x16 multiplier:
// each face takes a table read, three products, a final sum and a compare, so
// after a query transfer the input side stalls until the walk and the result
// step are through, which ends sooner when a face rejects the point early. One
// result per query waits in the output register; the next item is taken while
// it waits, and only its own result step stalls on it.
module point_convex_penetration_top (
   input  logic                                     clock,
   input  logic                                     reset,
   // configuration writes
   input  logic                                     csr_wr_en,
   input  logic [pcp_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [pcp_pkg::CSR_DATA_W-1:0]           csr_wdata,
   // input items
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [pcp_pkg::CMD_W-1:0]                req_command,
   input  logic [pcp_pkg::SLOT_W-1:0]               req_face_slot,
   input  logic signed [pcp_pkg::NORM_W-1:0]        req_normal_x,
   input  logic signed [pcp_pkg::NORM_W-1:0]        req_normal_y,
   input  logic signed [pcp_pkg::NORM_W-1:0]        req_normal_z,
   input  logic signed [pcp_pkg::COORD_W-1:0]       req_coord_x,
   input  logic signed [pcp_pkg::COORD_W-1:0]       req_coord_y,
   input  logic signed [pcp_pkg::COORD_W-1:0]       req_coord_z,
   // results
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_hit,
   output logic [pcp_pkg::SLOT_W-1:0]               rsp_nearest_face,
   output logic [pcp_pkg::DEPTH_W-1:0]              rsp_depth,
   output logic signed [pcp_pkg::NORM_W-1:0]        rsp_contact_normal_x,
   output logic signed [pcp_pkg::NORM_W-1:0]        rsp_contact_normal_y,
   output logic signed [pcp_pkg::NORM_W-1:0]        rsp_contact_normal_z,
   output logic signed [pcp_pkg::COORD_W-1:0]      rsp_contact_x,
   output logic signed [pcp_pkg::COORD_W-1:0]      rsp_contact_y,
   output logic signed [pcp_pkg::COORD_W-1:0]      rsp_contact_z
);

   localparam int IDX_W = pcp_pkg::FACE_IDX_W;
   localparam int CNT_W = pcp_pkg::FACE_CNT_W;
   localparam int DST_W = pcp_pkg::DIST_W;

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_EVAL = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   // Axis codes for the shared multiplier
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Configuration registers
   logic [pcp_pkg::CFG_CNT_W-1:0] face_count_ff;
   logic [pcp_pkg::TOL_W-1:0]     surface_tol_ff;
   logic                          tolerant_mode_ff;

   // Face table
   pcp_pkg::face_entry_type face_mem [pcp_pkg::MAX_FACES];
   pcp_pkg::face_entry_type entry_ff;

   // Sequencer and datapath registers
   logic [2:0]                            state_ff, state_in;
   logic [1:0]                            axis_ff, axis_in;
   logic [IDX_W-1:0]                      face_idx_ff, face_idx_in;
   logic signed [pcp_pkg::COORD_W-1:0]    px_ff, py_ff, pz_ff;
   logic signed [pcp_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic signed [DST_W-1:0]               acc_ff, acc_in;
   logic                                  found_ff, found_in;
   logic                                  reject_ff, reject_in;
   logic signed [DST_W-1:0]               best_d_ff, best_d_in;
   logic [IDX_W-1:0]                      best_idx_ff, best_idx_in;
   logic signed [pcp_pkg::NORM_W-1:0]     best_nx_ff, best_ny_ff, best_nz_ff;
   logic                                  best_upd;

   // Output register
   logic                                  rsp_valid_ff;
   logic                                  rsp_hit_ff;
   logic [pcp_pkg::SLOT_W-1:0]            rsp_face_ff;
   logic [pcp_pkg::DEPTH_W-1:0]           rsp_depth_ff;
   logic signed [pcp_pkg::NORM_W-1:0]     rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic signed [pcp_pkg::COORD_W-1:0]    rsp_px_ff, rsp_py_ff, rsp_pz_ff;

   logic                                  req_xfer;
   logic                                  rsp_xfer;
   logic                                  out_free;
   logic                                  rsp_load;
   logic [CNT_W-1:0]                      count_eff;
   logic [CNT_W-1:0]                      idx_next;
   logic                                  last_face;
   logic signed [pcp_pkg::COORD_W-1:0]    p_sel, r_sel;
   logic signed [pcp_pkg::NORM_W-1:0]     n_sel;
   logic signed [pcp_pkg::DIFF_W-1:0]     diff;
   logic signed [DST_W-1:0]               tol_q30;
   logic                                  d_nonneg;
   logic                                  d_in_band;
   logic [pcp_pkg::ROUND_W-1:0]           neg_round;
   logic [pcp_pkg::QUOT_W-1:0]            quot;
   logic [pcp_pkg::DEPTH_W-1:0]           depth_sat;
   logic                                  hit_now;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_load = (state_ff == ST_DONE) && out_free;

   // Clamp the face count to the table depth
   always_comb begin
      if (int'(face_count_ff) > pcp_pkg::MAX_FACES) begin
         count_eff = CNT_W'(pcp_pkg::MAX_FACES);
      end else begin
         count_eff = CNT_W'(face_count_ff);
      end
   end

   assign idx_next  = {1'b0, face_idx_ff} + CNT_W'(1);
   assign last_face = (idx_next == count_eff);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         face_count_ff    <= pcp_pkg::FACE_COUNT_RST;
         surface_tol_ff   <= pcp_pkg::SURFACE_TOL_RST;
         tolerant_mode_ff <= pcp_pkg::TOLERANT_MODE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pcp_pkg::CSR_FACE_COUNT: begin
               face_count_ff <= csr_wdata[pcp_pkg::CFG_CNT_W-1:0];
            end
            pcp_pkg::CSR_SURFACE_TOL: begin
               surface_tol_ff <= csr_wdata[pcp_pkg::TOL_W-1:0];
            end
            pcp_pkg::CSR_TOLERANT_MODE: begin
               tolerant_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Face table: write on a load transfer, registered read for the walk
   always_ff @(posedge clock) begin
      if (req_xfer && (req_command == pcp_pkg::CMD_LOAD)
            && (int'(req_face_slot) < pcp_pkg::MAX_FACES)) begin
         face_mem[IDX_W'(req_face_slot)] <= '{nx: req_normal_x, ny: req_normal_y,
                                              nz: req_normal_z, rx: req_coord_x,
                                              ry: req_coord_y, rz: req_coord_z};
      end
      if (state_ff == ST_READ) begin
         entry_ff <= face_mem[face_idx_ff];
      end
   end

   // Select the operands of the shared multiplier
   always_comb begin
      case (axis_ff)
         AXIS_X: begin
            p_sel = px_ff;
            r_sel = entry_ff.rx;
            n_sel = entry_ff.nx;
         end
         AXIS_Y: begin
            p_sel = py_ff;
            r_sel = entry_ff.ry;
            n_sel = entry_ff.ny;
         end
         default: begin
            p_sel = pz_ff;
            r_sel = entry_ff.rz;
            n_sel = entry_ff.nz;
         end
      endcase
   end

   assign diff    = pcp_pkg::DIFF_W'(p_sel) - pcp_pkg::DIFF_W'(r_sel);
   assign prod_in = diff * n_sel;

   // Face test against the finished distance in acc_ff
   assign tol_q30   = DST_W'({surface_tol_ff, {pcp_pkg::FRAC_SHIFT{1'b0}}});
   assign d_nonneg  = !acc_ff[DST_W-1];
   assign d_in_band = tolerant_mode_ff && (acc_ff <= tol_q30);
   assign best_upd  = (state_ff == ST_EVAL) && !d_nonneg
                      && (!found_ff || (acc_ff > best_d_ff));

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      face_idx_in = face_idx_ff;
      acc_in      = acc_ff;
      found_in    = found_ff;
      reject_in   = reject_ff;
      best_d_in   = best_d_ff;
      best_idx_in = best_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_command == pcp_pkg::CMD_QUERY)) begin
               face_idx_in = '0;
               found_in    = 1'b0;
               reject_in   = 1'b0;
               best_d_in   = '0;
               best_idx_in = '0;
               state_in    = (count_eff == '0) ? ST_DONE : ST_READ;
            end
         end
         ST_READ: begin
            axis_in  = AXIS_X;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // accumulate the previous product while the next one forms
            acc_in = (axis_ff == AXIS_X) ? '0 : acc_ff + DST_W'(prod_ff);
            if (axis_ff == AXIS_Z) begin
               state_in = ST_SUM;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_SUM: begin
            acc_in   = acc_ff + DST_W'(prod_ff);
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (d_nonneg && !d_in_band) begin
               reject_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               if (best_upd) begin
                  found_in    = 1'b1;
                  best_d_in   = acc_ff;
                  best_idx_in = face_idx_ff;
               end
               face_idx_in = idx_next[IDX_W-1:0];
               state_in    = last_face ? ST_DONE : ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         found_ff  <= 1'b0;
         reject_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         found_ff  <= found_in;
         reject_ff <= reject_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      face_idx_ff <= face_idx_in;
      acc_ff      <= acc_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end
      if (req_xfer) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
         pz_ff <= req_coord_z;
      end
      if (best_upd) begin
         best_nx_ff <= entry_ff.nx;
         best_ny_ff <= entry_ff.ny;
         best_nz_ff <= entry_ff.nz;
      end
   end

   // Depth: negate, round half up, saturate to unsigned Q15.16
   assign neg_round = pcp_pkg::ROUND_W'(-best_d_ff) + pcp_pkg::ROUND_HALF;
   assign quot      = neg_round[pcp_pkg::ROUND_W-1:pcp_pkg::FRAC_SHIFT];
   assign depth_sat = (quot > pcp_pkg::QUOT_W'(pcp_pkg::DEPTH_MAX))
                      ? pcp_pkg::DEPTH_MAX : quot[pcp_pkg::DEPTH_W-1:0];
   assign hit_now   = found_ff && !reject_ff;

   // Output register: load in the result step, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff   <= hit_now;
         rsp_face_ff  <= hit_now ? pcp_pkg::SLOT_W'(best_idx_ff) : '0;
         rsp_depth_ff <= hit_now ? depth_sat : '0;
         rsp_nx_ff    <= hit_now ? best_nx_ff : '0;
         rsp_ny_ff    <= hit_now ? best_ny_ff : '0;
         rsp_nz_ff    <= hit_now ? best_nz_ff : '0;
         rsp_px_ff    <= px_ff;
         rsp_py_ff    <= py_ff;
         rsp_pz_ff    <= pz_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_nearest_face     = rsp_face_ff;
   assign rsp_depth            = rsp_depth_ff;
   assign rsp_contact_normal_x = rsp_nx_ff;
   assign rsp_contact_normal_y = rsp_ny_ff;
   assign rsp_contact_normal_z = rsp_nz_ff;
   assign rsp_contact_x        = rsp_px_ff;
   assign rsp_contact_y        = rsp_py_ff;
   assign rsp_contact_z        = rsp_pz_ff;

   // A kept best distance is always a penetration
   a_best_negative: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> best_d_ff[DST_W-1])
      else $error("best distance kept while not negative");

   // A new result only comes out of the result step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the result step");

   // A miss carries no depth and no face
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> ((rsp_depth_ff == '0) && (rsp_face_ff == '0)))
      else $error("miss result carries depth or face");

   // The walk never reads past the active faces
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_EVAL))
         |-> ({1'b0, face_idx_ff} < count_eff))
      else $error("face index beyond face count");

endmodule
